// ===== rtl/mch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_pkg
// Shared constants for the compass heading CORDIC: datapath widths, angle
// units and the arctangent table.
// ----------------------------------------------------------------------------
package mch_pkg;

   // input count width and guard bits added below the binary point
   localparam int IN_W       = 16;
   localparam int GUARD_BITS = 24;

   // x/y datapath: 17-bit magnitude after the half-plane fold, guard bits,
   // plus headroom for the CORDIC gain of about 1.65 on a diagonal vector
   localparam int DATA_W = 43;

   // angle accumulator in units of 2^-20 degree, range about -100..280 degrees
   localparam int ANG_FRAC = 20;
   localparam int ANG_W    = 30;

   // heading output width
   localparam int OUT_W = 15;

   // number of table entries, and so the most iterations that can run
   localparam int TABLE_LEN = 24;

   // 180 and 360 degrees in accumulator units
   localparam logic signed [ANG_W-1:0] HALF_TURN = 30'sd188743680;
   localparam logic signed [ANG_W-1:0] FULL_TURN = 30'sd377487360;

   // atan(2^-i) in accumulator units, rounded to nearest
   localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
      30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
      30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
      30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
      30'sd917,      30'sd458,      30'sd229,      30'sd115,
      30'sd57,       30'sd29,       30'sd14,       30'sd7
   };

   // one CORDIC pipeline stage payload
   typedef struct packed {
      logic                     zero;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [ANG_W-1:0]  z;
   } stage_type;

endpackage

// ===== rtl/magnetometer_compass_heading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_compass_heading
// Compass heading atan2(Y, X) in [0, 360) degrees from one X/Y magnetometer
// reading, by a fully pipelined CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
//
//  channel   ports                                  direction  flow control
//  -------   -------------------------------------  ---------  ----------------
//  request   start, busy, req_mag_x, req_mag_y      in         start && !busy
//  response  rsp_valid, rsp_heading_deg             out        one-cycle strobe
//
//  One reading enters per cycle; busy stays low, the pipeline never stalls.
//  The pipeline has one fold stage, one stage per micro-rotation, an angle
//  wrap stage and a rounding stage that doubles as the output register.
//  Reset clears only the valid bits; payload registers are not reset.
//  The receiver cannot hold off a response beat; each is shown for one cycle.
//
module magnetometer_compass_heading #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [mch_pkg::IN_W-1:0]     req_mag_x,
   input  logic signed [mch_pkg::IN_W-1:0]     req_mag_y,
   output logic                                rsp_valid,
   output logic        [mch_pkg::OUT_W-1:0]    rsp_heading_deg
);

   localparam int NSTEP = (CORDIC_STEPS < mch_pkg::TABLE_LEN) ?
                          CORDIC_STEPS : mch_pkg::TABLE_LEN;
   localparam int MAG_W     = mch_pkg::IN_W + 1;
   localparam int RND_SHIFT = mch_pkg::ANG_FRAC - FRAC_BITS;
   localparam int FULL_OUT  = 360 << FRAC_BITS;
   localparam logic [mch_pkg::ANG_W-1:0] ROUND_ADD =
      mch_pkg::ANG_W'(1) << (RND_SHIFT - 1);
   localparam logic [mch_pkg::ANG_W-1:0] FULL_OUT_V = mch_pkg::ANG_W'(FULL_OUT);
   localparam bit OUT_FITS = (FULL_OUT <= (1 << mch_pkg::OUT_W));

   // stage registers: index 0 holds the folded input, index i the result
   // of i micro-rotations
   logic                vld_ff [NSTEP+1];
   mch_pkg::stage_type  stg_ff [NSTEP+1];

   logic                        wrap_vld_ff;
   logic                        wrap_zero_ff;
   logic [mch_pkg::ANG_W-1:0]   wrap_ff;
   logic                        rsp_valid_ff;
   logic [mch_pkg::OUT_W-1:0]   rsp_heading_ff;

   logic                        accept;
   logic signed [MAG_W-1:0]     mx;
   logic signed [MAG_W-1:0]     my;
   logic                        neg;
   mch_pkg::stage_type          stg0_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // fold into the right half plane: if x is negative, negate both axes and add 180 degrees
   always_comb begin
      mx = {req_mag_x[mch_pkg::IN_W-1], req_mag_x};
      my = {req_mag_y[mch_pkg::IN_W-1], req_mag_y};
      neg = mx[MAG_W-1];
      if (neg) begin
         mx = -mx;
         my = -my;
      end
      stg0_in.zero = (req_mag_x == '0) && (req_mag_y == '0);
      stg0_in.x    = {{(mch_pkg::DATA_W-MAG_W){mx[MAG_W-1]}}, mx} <<< mch_pkg::GUARD_BITS;
      stg0_in.y    = {{(mch_pkg::DATA_W-MAG_W){my[MAG_W-1]}}, my} <<< mch_pkg::GUARD_BITS;
      stg0_in.z    = neg ? mch_pkg::HALF_TURN : '0;
   end

   // fold stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
      end
      stg_ff[0] <= stg0_in;
   end

   // one micro-rotation per stage, driving y toward zero
   for (genvar i = 0; i < NSTEP; i++) begin : g_rot
      mch_pkg::stage_type rot_in;

      always_comb begin
         rot_in.zero = stg_ff[i].zero;
         if (!stg_ff[i].y[mch_pkg::DATA_W-1]) begin
            rot_in.x = stg_ff[i].x + (stg_ff[i].y >>> i);
            rot_in.y = stg_ff[i].y - (stg_ff[i].x >>> i);
            rot_in.z = stg_ff[i].z + mch_pkg::ATAN_TAB[i];
         end else begin
            rot_in.x = stg_ff[i].x - (stg_ff[i].y >>> i);
            rot_in.y = stg_ff[i].y + (stg_ff[i].x >>> i);
            rot_in.z = stg_ff[i].z - mch_pkg::ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         stg_ff[i+1] <= rot_in;
      end
   end

   // wrap the angle into [0, 360)
   logic signed [mch_pkg::ANG_W-1:0] z_last;
   logic signed [mch_pkg::ANG_W-1:0] wrap_in;

   always_comb begin
      z_last = stg_ff[NSTEP].z;
      priority if (z_last < 0) begin
         wrap_in = z_last + mch_pkg::FULL_TURN;
      end else if (z_last >= mch_pkg::FULL_TURN) begin
         wrap_in = z_last - mch_pkg::FULL_TURN;
      end else begin
         wrap_in = z_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_vld_ff <= 1'b0;
      end else begin
         wrap_vld_ff <= vld_ff[NSTEP];
      end
      wrap_zero_ff <= stg_ff[NSTEP].zero;
      wrap_ff      <= wrap_in;
   end

   // round half up to the output fraction, 360 wraps to 0
   logic [mch_pkg::ANG_W-1:0] rnd_sum;
   logic [mch_pkg::ANG_W-1:0] rnd_val;
   logic [mch_pkg::OUT_W-1:0] heading_in;

   always_comb begin
      rnd_sum = (wrap_ff + ROUND_ADD) >> RND_SHIFT;
      if (rnd_sum >= FULL_OUT_V) begin
         rnd_val = rnd_sum - FULL_OUT_V;
      end else begin
         rnd_val = rnd_sum;
      end
      heading_in = wrap_zero_ff ? '0 : rnd_val[mch_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= wrap_vld_ff;
      end
      rsp_heading_ff <= heading_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_deg = rsp_heading_ff;

   // folded vector always lies in the right half plane
   a_fold_right: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> !stg_ff[0].x[mch_pkg::DATA_W-1])
      else $error("folded x is negative");

   // after the rotations a nonzero vector ends on the positive x axis
   a_rot_xpos: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTEP] && !stg_ff[NSTEP].zero) |-> (stg_ff[NSTEP].x > 0))
      else $error("rotated x not positive");

   // wrapped angle lies in [0, 360)
   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      wrap_vld_ff |-> (wrap_ff < mch_pkg::FULL_TURN))
      else $error("wrapped angle out of range");

   // response beat follows a valid wrap stage and stays below a full turn
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && OUT_FITS) |->
         ($past(wrap_vld_ff) && (32'(rsp_heading_deg) < FULL_OUT)))
      else $error("heading out of range");

endmodule
